>>> rtl/core/scp_pkg.sv
`default_nettype none

package scp_pkg;

   localparam int ANGLE_FRAC_BITS_DEF = 28;
   localparam int OUT_FRAC_BITS_DEF   = 30;

   localparam int IoW       = 32;
   localparam int AngW      = 34;
   localparam int XW        = 32;
   localparam int XqFrac    = 28;
   localparam int SW        = 31;
   localparam int RW        = 36;
   localparam int CoefFrac  = 32;
   localparam int WideW     = 72;
   localparam int SqShift   = 30;
   localparam int HornShift = 26;
   localparam int StepCount = 5;

   localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
   localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1847;
   localparam logic [63:0] TWO_PI_Q60  = 64'h6487ED5110B4611A;

   typedef struct packed {
      logic signed [XW-1:0] xq;
      logic signed [SW-1:0] s;
      logic signed [RW-1:0] rs;
      logic signed [RW-1:0] rc;
      logic                 flip;
   } scp_item_type;

   function automatic logic signed [AngW-1:0] angle_const(input logic [63:0] c,
                                                          input int frac);
      logic [63:0] v;
      int          sh;
      sh = 60 - frac;
      v  = (c + (64'd1 << (sh - 1))) >> sh;
      return $signed(v[AngW-1:0]);
   endfunction

   function automatic logic signed [RW-1:0] sin_coef(input int idx);
      logic signed [RW-1:0] c;
      case (idx)
         0:       c = -36'sd103;
         1:       c = 36'sd11822;
         2:       c = -36'sd852159;
         3:       c = 36'sd35791384;
         4:       c = -36'sd715827897;
         5:       c = 36'sd4294967296;
         default: c = '0;
      endcase
      return c;
   endfunction

   function automatic logic signed [RW-1:0] cos_coef(input int idx);
      logic signed [RW-1:0] c;
      case (idx)
         0:       c = -36'sd1119;
         1:       c = 36'sd106346;
         2:       c = -36'sd5965013;
         3:       c = 36'sd178956848;
         4:       c = -36'sd2147483648;
         5:       c = 36'sd4294967296;
         default: c = '0;
      endcase
      return c;
   endfunction

   // round to nearest, ties away from zero, then shift right
   function automatic logic signed [WideW-1:0] round_shr(input logic signed [WideW-1:0] v,
                                                         input int sh);
      logic signed [WideW-1:0] half;
      half         = '0;
      half[sh - 1] = 1'b1;
      if (v[WideW-1]) begin
         half = half - WideW'(1);
      end
      return (v + half) >>> sh;
   endfunction

   function automatic logic signed [IoW-1:0] sat32(input logic signed [WideW-1:0] v);
      logic signed [IoW-1:0] r;
      if (v[WideW-1:IoW-1] == {(WideW-IoW+1){v[WideW-1]}}) begin
         r = v[IoW-1:0];
      end else if (v[WideW-1]) begin
         r = {1'b1, {(IoW-1){1'b0}}};
      end else begin
         r = {1'b0, {(IoW-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/sincos_polynomial.sv
// Sine and cosine of one angle per request.
// Request channel: req_valid/req_ready carry req_angle, radians, signed with
// ANGLE_FRAC_BITS fraction bits. Response channel: rsp_valid/rsp_ready carry
// rsp_sine and rsp_cosine, signed with OUT_FRAC_BITS fraction bits, saturated.
// Angles beyond +/-2*pi fold to -/+2*pi; magnitudes above pi/2 are reflected
// through +/-pi with the cosine negated.
// Stages: fold, square, five Horner cells, product, round/saturate; nine
// registers, the first loaded at the accepting edge. Throughput: one
// request per cycle while rsp_ready is high;
// each stage holds one request and passes it on in every cycle its
// successor has room.
// Reset (synchronous, active high) empties every stage; no response is
// pending afterwards and req_ready is high.
// When the receiver stalls, the response holds in the output register and
// the stages behind it keep filling, so requests are still accepted until
// all nine stages are full; req_ready then follows rsp_ready.
`default_nettype none

module sincos_polynomial #(
   parameter int ANGLE_FRAC_BITS = scp_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int OUT_FRAC_BITS   = scp_pkg::OUT_FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [scp_pkg::IoW-1:0]     req_angle,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [scp_pkg::IoW-1:0]     rsp_sine,
   output logic signed [scp_pkg::IoW-1:0]     rsp_cosine
);

   localparam int StepCount = scp_pkg::StepCount;

   logic                  st_valid [0:StepCount];
   logic                  st_ready [0:StepCount];
   scp_pkg::scp_item_type st_item  [0:StepCount];

   scp_reduce #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_reduce (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .angle     (req_angle),
      .out_valid (st_valid[0]),
      .out_ready (st_ready[0]),
      .out_item  (st_item[0])
   );

   for (genvar k = 0; k < StepCount; k++) begin : g_cell
      scp_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .coef_sin  (scp_pkg::sin_coef(k + 1)),
         .coef_cos  (scp_pkg::cos_coef(k + 1)),
         .in_valid  (st_valid[k]),
         .in_ready  (st_ready[k]),
         .in_item   (st_item[k]),
         .out_valid (st_valid[k+1]),
         .out_ready (st_ready[k+1]),
         .out_item  (st_item[k+1])
      );
   end

   scp_finish #(
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
   ) u_finish (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (st_valid[StepCount]),
      .in_ready  (st_ready[StepCount]),
      .in_item   (st_item[StepCount]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .sine      (rsp_sine),
      .cosine    (rsp_cosine)
   );

   reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response pending after reset");

   ready_when_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_ready || !rsp_valid) |-> req_ready)
      else $error("request stalled while output drains");

   rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_sine) && $stable(rsp_cosine)))
      else $error("response changed while stalled");

endmodule

`default_nettype wire

>>> rtl/core/scp_reduce.sv
`default_nettype none

module scp_reduce #(
   parameter int ANGLE_FRAC_BITS = scp_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic signed [scp_pkg::IoW-1:0]     angle,
   output logic                               out_valid,
   input  logic                               out_ready,
   output scp_pkg::scp_item_type              out_item
);

   localparam int AngW = scp_pkg::AngW;
   localparam int XW   = scp_pkg::XW;
   localparam int SqW  = 2 * XW;
   localparam int Up   = scp_pkg::XqFrac - ANGLE_FRAC_BITS;
   localparam logic signed [AngW-1:0] TwoPi =
      scp_pkg::angle_const(scp_pkg::TWO_PI_Q60, ANGLE_FRAC_BITS);
   localparam logic signed [AngW-1:0] Pi =
      scp_pkg::angle_const(scp_pkg::PI_Q60, ANGLE_FRAC_BITS);
   localparam logic signed [AngW-1:0] HalfPi =
      scp_pkg::angle_const(scp_pkg::HALF_PI_Q60, ANGLE_FRAC_BITS);
   localparam logic signed [XW-1:0] XqLimit = XW'(64'd1 << (scp_pkg::XqFrac + 2));

   logic signed [AngW-1:0] x_wide;
   logic signed [AngW-1:0] x_fold;
   logic signed [AngW-1:0] x_abs;
   logic signed [AngW-1:0] x_refl;

   logic                   a_valid_ff;
   logic signed [XW-1:0]   a_xq_ff;
   logic signed [XW-1:0]   a_xq_in;
   logic                   a_flip_ff;
   logic                   a_flip_in;
   logic                   a_ready;

   logic                   b_valid_ff;
   scp_pkg::scp_item_type  b_item_ff;
   scp_pkg::scp_item_type  b_item_in;
   logic                   b_ready;
   logic signed [SqW-1:0]  sq;

   // fold and reflect
   always_comb begin
      x_wide = AngW'(angle);
      if (x_wide > TwoPi) begin
         x_fold = -TwoPi;
      end else if (x_wide < -TwoPi) begin
         x_fold = TwoPi;
      end else begin
         x_fold = x_wide;
      end
      x_abs     = x_fold[AngW-1] ? -x_fold : x_fold;
      a_flip_in = x_abs > HalfPi;
      if (a_flip_in) begin
         x_refl = (x_fold[AngW-1] ? -Pi : Pi) - x_fold;
      end else begin
         x_refl = x_fold;
      end
      a_xq_in = XW'(x_refl <<< Up);
   end

   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= in_valid;
      end
      if (in_valid && a_ready) begin
         a_xq_ff   <= a_xq_in;
         a_flip_ff <= a_flip_in;
      end
   end

   // square and seed the accumulators
   assign sq = a_xq_ff * a_xq_ff;

   always_comb begin
      b_item_in.xq   = a_xq_ff;
      b_item_in.s    = scp_pkg::SW'(scp_pkg::round_shr(scp_pkg::WideW'(sq),
                                                      scp_pkg::SqShift));
      b_item_in.rs   = scp_pkg::sin_coef(0);
      b_item_in.rc   = scp_pkg::cos_coef(0);
      b_item_in.flip = a_flip_ff;
   end

   assign b_ready = !b_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
      if (a_valid_ff && b_ready) begin
         b_item_ff <= b_item_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_item  = b_item_ff;

   a_xq_range: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff |-> (a_xq_ff < XqLimit && a_xq_ff > -XqLimit))
      else $error("reduced angle out of range");

   b_square_sign: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> !b_item_ff.s[scp_pkg::SW-1])
      else $error("square is negative");

endmodule

`default_nettype wire

>>> rtl/core/scp_cell.sv
`default_nettype none

module scp_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  logic signed [scp_pkg::RW-1:0]      coef_sin,
   input  logic signed [scp_pkg::RW-1:0]      coef_cos,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  scp_pkg::scp_item_type              in_item,
   output logic                               out_valid,
   input  logic                               out_ready,
   output scp_pkg::scp_item_type              out_item
);

   localparam int PW = scp_pkg::RW + scp_pkg::SW;

   logic                  valid_ff;
   scp_pkg::scp_item_type item_ff;
   scp_pkg::scp_item_type item_in;
   logic signed [PW-1:0]  ps;
   logic signed [PW-1:0]  pc;

   // one Horner step for both polynomials
   assign ps = $signed(in_item.rs) * $signed(in_item.s);
   assign pc = $signed(in_item.rc) * $signed(in_item.s);

   always_comb begin
      item_in    = in_item;
      item_in.rs = scp_pkg::RW'(scp_pkg::round_shr(scp_pkg::WideW'(ps),
                                                  scp_pkg::HornShift)) + coef_sin;
      item_in.rc = scp_pkg::RW'(scp_pkg::round_shr(scp_pkg::WideW'(pc),
                                                  scp_pkg::HornShift)) + coef_cos;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

>>> rtl/core/scp_finish.sv
`default_nettype none

module scp_finish #(
   parameter int OUT_FRAC_BITS = scp_pkg::OUT_FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  scp_pkg::scp_item_type              in_item,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic signed [scp_pkg::IoW-1:0]     sine,
   output logic signed [scp_pkg::IoW-1:0]     cosine
);

   localparam int RW        = scp_pkg::RW;
   localparam int IoW       = scp_pkg::IoW;
   localparam int WideW     = scp_pkg::WideW;
   localparam int PW        = scp_pkg::RW + scp_pkg::XW;
   localparam int SineShift = scp_pkg::CoefFrac + scp_pkg::XqFrac - OUT_FRAC_BITS;
   localparam int CosShift  = scp_pkg::CoefFrac - OUT_FRAC_BITS;

   logic                   m_valid_ff;
   logic signed [PW-1:0]   m_prod_ff;
   logic signed [PW-1:0]   m_prod_in;
   logic signed [RW-1:0]   m_rc_ff;
   logic                   m_flip_ff;
   logic                   m_ready;

   logic                   o_valid_ff;
   logic signed [IoW-1:0]  sine_ff;
   logic signed [IoW-1:0]  sine_in;
   logic signed [IoW-1:0]  cosine_ff;
   logic signed [IoW-1:0]  cosine_in;
   logic signed [WideW-1:0] cos_round;
   logic                   o_ready;

   assign m_prod_in = $signed(in_item.rs) * $signed(in_item.xq);
   assign m_ready   = !m_valid_ff || o_ready;
   assign in_ready  = m_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (m_ready) begin
         m_valid_ff <= in_valid;
      end
      if (in_valid && m_ready) begin
         m_prod_ff <= m_prod_in;
         m_rc_ff   <= in_item.rc;
         m_flip_ff <= in_item.flip;
      end
   end

   // round, negate the cosine on reflection, saturate
   always_comb begin
      sine_in   = scp_pkg::sat32(scp_pkg::round_shr(WideW'(m_prod_ff), SineShift));
      cos_round = scp_pkg::round_shr(WideW'(m_rc_ff), CosShift);
      if (m_flip_ff) begin
         cos_round = -cos_round;
      end
      cosine_in = scp_pkg::sat32(cos_round);
   end

   assign o_ready = !o_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (o_ready) begin
         o_valid_ff <= m_valid_ff;
      end
      if (m_valid_ff && o_ready) begin
         sine_ff   <= sine_in;
         cosine_ff <= cosine_in;
      end
   end

   assign out_valid = o_valid_ff;
   assign sine      = sine_ff;
   assign cosine    = cosine_ff;

endmodule

`default_nettype wire
